[design/fps_pkg.sv]
// fps_pkg: types and constants for the farthest point sampler
// no dependencies
package fps_pkg;
  localparam int unsigned MaxPoints  = 1024;
  localparam int unsigned MaxDim     = 8;
  localparam int unsigned MaxSamples = 64;
  localparam int unsigned CoordBits  = 16;
  localparam int unsigned IdxW  = $clog2(MaxPoints);
  localparam int unsigned CntW  = IdxW + 1;
  localparam int unsigned DistW = 2 * CoordBits + 6;
  localparam int unsigned DimW  = $clog2(MaxDim) + 1;

  localparam logic [1:0] RegSampleCount = 2'd0;
  localparam logic [1:0] RegStartIndex  = 2'd1;
  localparam logic [1:0] RegDimsInUse   = 2'd2;

  typedef struct packed {
    logic signed [15:0] coord_7;
    logic signed [15:0] coord_6;
    logic signed [15:0] coord_5;
    logic signed [15:0] coord_4;
    logic signed [15:0] coord_3;
    logic signed [15:0] coord_2;
    logic signed [15:0] coord_1;
    logic signed [15:0] coord_0;
    logic               point_valid;
    logic               last_point;
  } fps_in_t;

  typedef struct packed {
    logic [9:0] sample_index;
    logic       last_sample;
  } fps_out_t;

  typedef enum logic [2:0] {
    StLoad, StCentRd, StCentLd, StScan, StDrain, StEmit, StRepeat
  } fps_state_e;
endpackage

[design/farthest_point_sampler.sv]
// farthest_point_sampler: point store and farthest point sampling engine
// depends on fps_pkg
//
//  word     dir  handshake           payload
//  in       in   start_i & !busy_o   in_i   (fps_in_t)
//  result   out  result_valid_o      result_o (fps_out_t)
//  config   in   cfg_we_i            cfg_idx_i, cfg_data_i
//
// points load while busy_o is low, a new point with each accept. after the
// last point each sample takes one memory read per point for the distance
// update and argmax, with a 3-stage pipeline (read, multiply, sum/compare).
// with no valid point the start centroid goes out at one word per cycle.
// reset clears the state, counters and config registers; the memories need no clearing.
// the receiver cannot stall, results are a one-cycle strobe.
module farthest_point_sampler import fps_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  fps_in_t        in_i,
  output logic           busy_o,
  output logic           result_valid_o,
  output fps_out_t       result_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [9:0]     cfg_data_i
);
  localparam int unsigned CW = CoordBits;
  localparam int unsigned PW = 2 * CW + 2;

  logic [MaxDim*CW-1:0] coord_mem [MaxPoints];
  logic [DistW:0]       dist_mem  [MaxPoints];   // valid flag on top

  logic [6:0]     samples_q;
  logic [IdxW-1:0] start_q;
  logic [3:0]     dims_q;

  fps_state_e     state_q, state_d;
  logic [CntW-1:0] loaded_q, loaded_d, valid_cnt_q, valid_cnt_d;
  logic [IdxW-1:0] cent_q, cent_d;
  logic [6:0]     done_q, done_d, k_q, k_d;
  logic [CntW-1:0] rd_q, rd_d;
  logic           first_q, first_d;
  logic [MaxDim*CW-1:0] cent_crd_q, cent_crd_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic [DistW-1:0] peak_dist_q, peak_dist_d;
  logic [DimW-1:0] dims_eff;

  // pipeline
  logic           s1_v_q, s2_v_q;
  logic [IdxW-1:0] s1_idx_q, s2_idx_q;
  logic [MaxDim*CW-1:0] crd_rd_q;
  logic [DistW:0] dist_rd_q, s2_dist_q;
  logic [PW-1:0]  sq_q [MaxDim];
  logic [IdxW-1:0] rd_addr;
  logic           rd_en;

  logic           mem_we;
  logic [IdxW-1:0] mem_wa;
  logic [DistW:0] mem_wd;
  logic [DistW-1:0] sum, newd;

  always_comb begin
    dims_eff = dims_q[DimW-1:0];
    if (dims_q == 4'd0) dims_eff = DimW'(1);
    else if (dims_q > 4'(MaxDim)) dims_eff = DimW'(MaxDim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q <= '0;
      start_q <= '0;
      dims_q <= 4'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSampleCount: samples_q <= cfg_data_i[6:0];
        RegStartIndex:  start_q <= cfg_data_i[IdxW-1:0];
        RegDimsInUse:   dims_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign busy_o = (state_q != StLoad);
  wire accept = start_i && !busy_o;
  wire store_pt = accept && (loaded_q < CntW'(MaxPoints));

  always_comb begin
    rd_en = 1'b0;
    rd_addr = rd_q[IdxW-1:0];
    if (state_q == StCentRd) begin
      rd_en = 1'b1;
      rd_addr = cent_q;
    end else if (state_q == StScan) begin
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_pt) coord_mem[loaded_q[IdxW-1:0]] <= in_i[MaxDim*CW+1:2];
    if (rd_en) begin
      crd_rd_q <= coord_mem[rd_addr];
      dist_rd_q <= dist_mem[rd_addr];
    end
    if (mem_we) dist_mem[mem_wa] <= mem_wd;
  end

  // stage 2: squares
  always_ff @(posedge clk_i) begin
    for (int d = 0; d < MaxDim; d++) begin
      logic signed [CW:0] df;
      logic signed [PW-1:0] prod;
      df = $signed({crd_rd_q[d*CW+CW-1], crd_rd_q[d*CW +: CW]})
         - $signed({cent_crd_q[d*CW+CW-1], cent_crd_q[d*CW +: CW]});
      prod = df * df;
      sq_q[d] <= (d < int'(dims_eff)) ? $unsigned(prod) : '0;
    end
    s2_dist_q <= dist_rd_q;
    s2_idx_q <= s1_idx_q;
  end

  always_comb begin
    sum = '0;
    for (int d = 0; d < MaxDim; d++) sum = sum + DistW'(sq_q[d]);
    newd = s2_dist_q[DistW-1:0];
    if (first_q) newd = s2_dist_q[DistW] ? '1 : '0;
    if (s2_dist_q[DistW] && sum < newd) newd = sum;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = s2_idx_q;
    mem_wd = {s2_dist_q[DistW], newd};
    if (store_pt) begin
      mem_we = 1'b1;
      mem_wa = loaded_q[IdxW-1:0];
      mem_wd = {in_i.point_valid, {DistW{1'b0}}};
    end else if (s2_v_q) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    loaded_d = loaded_q;
    valid_cnt_d = valid_cnt_q;
    cent_d = cent_q;
    done_d = done_q;
    k_d = k_q;
    rd_d = rd_q;
    first_d = first_q;
    cent_crd_d = cent_crd_q;
    best_idx_d = best_idx_q;
    peak_dist_d = peak_dist_q;
    unique case (state_q)
      StLoad: if (accept) begin
        if (store_pt) begin
          loaded_d = loaded_q + 1'b1;
          if (in_i.point_valid) valid_cnt_d = valid_cnt_q + 1'b1;
        end
        if (in_i.last_point) begin
          cent_d = (CntW'(start_q) < loaded_d) ? start_q : '0;
          k_d = (samples_q > 7'(MaxSamples)) ? 7'(MaxSamples) : samples_q;
          done_d = '0;
          first_d = 1'b1;
          if (k_d == 7'd0) begin
            loaded_d = '0;
            valid_cnt_d = '0;
          end else if (valid_cnt_d == '0) state_d = StRepeat;
          else state_d = StCentRd;
        end
      end
      StRepeat: begin
        done_d = done_q + 1'b1;
        if (done_d == k_q) begin
          state_d = StLoad;
          loaded_d = '0;
          valid_cnt_d = '0;
        end
      end
      StCentRd: state_d = StCentLd;
      StCentLd: begin
        cent_crd_d = crd_rd_q;
        rd_d = '0;
        best_idx_d = '0;
        peak_dist_d = '0;
        state_d = StScan;
      end
      StScan: begin
        rd_d = rd_q + 1'b1;
        if (rd_d == loaded_q) state_d = StDrain;
      end
      StDrain: if (!s1_v_q && !s2_v_q) state_d = StEmit;
      StEmit: begin
        done_d = done_q + 1'b1;
        first_d = 1'b0;
        cent_d = best_idx_q;
        if (done_d == k_q) begin
          state_d = StLoad;
          loaded_d = '0;
          valid_cnt_d = '0;
        end else state_d = StCentRd;
      end
      default: state_d = StLoad;
    endcase
    if (s2_v_q && (s2_idx_q == '0 || newd > peak_dist_q)) begin
      peak_dist_d = newd;
      best_idx_d = s2_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      loaded_q <= '0;
      valid_cnt_q <= '0;
      cent_q <= '0;
      done_q <= '0;
      k_q <= '0;
      rd_q <= '0;
      first_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      loaded_q <= loaded_d;
      valid_cnt_q <= valid_cnt_d;
      cent_q <= cent_d;
      done_q <= done_d;
      k_q <= k_d;
      rd_q <= rd_d;
      first_q <= first_d;
      s1_v_q <= (state_q == StScan);
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cent_crd_q <= cent_crd_d;
    best_idx_q <= best_idx_d;
    peak_dist_q <= peak_dist_d;
    s1_idx_q <= rd_q[IdxW-1:0];
  end

  always_comb begin
    result_valid_o = (state_q == StEmit) || (state_q == StRepeat);
    result_o.sample_index = 10'(cent_q);
    result_o.last_sample = (done_q + 1'b1 == k_q);
  end
endmodule

[test/tb_top.sv]
// tb_top: self-checking testbench for farthest_point_sampler
// depends on fps_pkg and the farthest_point_sampler rtl
// directed table then random clouds, each result checked against a local predictor or a typed row's index
module tb_top;
  import fps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam longint unsigned DistAllOnes = (64'd1 << DistW) - 1;

  typedef enum logic {RowCfg, RowPoint} row_kind_e;
  typedef struct {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [9:0]  reg_val;
    logic [15:0] even_c;
    logic [15:0] odd_c;
    bit          valid;
    bit          last;
    bit          typed;
    int unsigned want_idx;
  } stim_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  fps_in_t  point_word;
  logic     busy;
  logic     res_valid;
  fps_out_t res_word;
  logic     cfg_we;
  logic [1:0] cfg_idx;
  logic [9:0] cfg_data;

  farthest_point_sampler dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .in_i(point_word), .busy_o(busy),
    .result_valid_o(res_valid), .result_o(res_word),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // predictor state
  int          coord_mem [MaxPoints][MaxDim];
  bit          valid_mem [MaxPoints];
  longint unsigned min_dist [MaxPoints];
  int unsigned pts_loaded, pts_valid;
  int unsigned num_samples, first_centroid, dim_count;

  fps_out_t    sample_q[$];
  int unsigned fail_count;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void append_word(ref fps_out_t q[$], input fps_out_t w);
    q.insert(q.size(), w);
  endfunction

  function automatic void sample_cloud(fps_in_t p, ref fps_out_t res[$]);
    int unsigned k, dims, cent, best;
    longint unsigned sq_sum, peak_dist;
    longint diff;
    if (pts_loaded < MaxPoints) begin
      for (int d = 0; d < MaxDim; d++) coord_mem[pts_loaded][d] = $signed(p[2 + 16*d +: 16]);
      valid_mem[pts_loaded] = p.point_valid;
      if (p.point_valid) pts_valid++;
      pts_loaded++;
    end
    if (!p.last_point) return;
    k = (num_samples > MaxSamples) ? MaxSamples : num_samples;
    dims = (dim_count < 1) ? 1 : (dim_count > MaxDim) ? MaxDim : dim_count;
    cent = (first_centroid < pts_loaded) ? first_centroid : 0;
    if (k != 0 && pts_valid == 0) begin
      for (int i = 0; i < k; i++) append_word(res, '{cent[9:0], i + 1 == k});
    end else if (k != 0) begin
      for (int n = 0; n < pts_loaded; n++) min_dist[n] = valid_mem[n] ? DistAllOnes : 0;
      for (int i = 0; i < k; i++) begin
        for (int n = 0; n < pts_loaded; n++) begin
          if (!valid_mem[n]) continue;
          sq_sum = 0;
          for (int d = 0; d < dims; d++) begin
            diff = longint'(coord_mem[n][d]) - longint'(coord_mem[cent][d]);
            sq_sum += longint'(diff * diff);
          end
          if (sq_sum < min_dist[n]) min_dist[n] = sq_sum;
        end
        append_word(res, '{cent[9:0], i + 1 == k});
        if (i + 1 < k) begin
          best = 0;
          peak_dist = min_dist[0];
          for (int n = 1; n < pts_loaded; n++) begin
            if (min_dist[n] > peak_dist) begin
              peak_dist = min_dist[n];
              best = n;
            end
          end
          cent = best;
        end
      end
    end
    pts_loaded = 0;
    pts_valid = 0;
  endfunction

  task automatic wait_idle();
    while (sample_q.size() != 0 || busy) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    wait_idle();
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      RegSampleCount: num_samples = val[6:0];
      RegStartIndex:  first_centroid = val;
      RegDimsInUse:   dim_count = val[3:0];
      default: ;
    endcase
  endtask

  // word held on the port until the block takes it
  task automatic send_point(fps_in_t p, bit may_idle, bit typed, int unsigned want_idx);
    fps_out_t res[$];
    int unsigned k;
    @(negedge clk);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    start = 1'b1;
    point_word = p;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sample_cloud(p, res);
    if (typed) begin
      k = (num_samples > MaxSamples) ? MaxSamples : num_samples;
      for (int i = 0; i < k; i++) append_word(sample_q, '{want_idx[9:0], i + 1 == k});
    end else begin
      foreach (res[i]) append_word(sample_q, res[i]);
    end
    if (p.last_point) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    fps_out_t want;
    if (res_valid) begin
      if (sample_q.size() == 0) begin
        $error("unexpected result word index %0d", res_word.sample_index);
        fail_count++;
      end else begin
        want = sample_q.pop_front();
        if (res_word.sample_index !== want.sample_index) begin
          $error("sample_index expected %0d actual %0d", want.sample_index,
                 res_word.sample_index);
          fail_count++;
        end
        if (res_word.last_sample !== want.last_sample) begin
          $error("last_sample expected %0d actual %0d", want.last_sample,
                 res_word.last_sample);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  stim_row_t dir_rows[] = '{
    '{RowCfg, RegSampleCount, 10'd0, 0, 0, 0, 0, 0, 0},
    '{RowPoint, 0, 0, 16'h0000, 16'h0000, 1, 1, 0, 0},
    '{RowCfg, RegSampleCount, 10'd3, 0, 0, 0, 0, 0, 0},
    '{RowCfg, RegStartIndex, 10'd5, 0, 0, 0, 0, 0, 0},
    '{RowCfg, RegDimsInUse, 10'd0, 0, 0, 0, 0, 0, 0},
    '{RowPoint, 0, 0, 16'h1111, 16'h2222, 0, 0, 0, 0},
    '{RowPoint, 0, 0, 16'h3333, 16'h4444, 0, 1, 1, 0},
    '{RowCfg, RegStartIndex, 10'd1, 0, 0, 0, 0, 0, 0},
    '{RowPoint, 0, 0, 16'h7fff, 16'h8000, 0, 0, 0, 0},
    '{RowPoint, 0, 0, 16'h8000, 16'h7fff, 0, 1, 1, 1},
    '{RowCfg, RegSampleCount, 10'd127, 0, 0, 0, 0, 0, 0},
    '{RowCfg, RegStartIndex, 10'd0, 0, 0, 0, 0, 0, 0},
    '{RowCfg, RegDimsInUse, 10'd15, 0, 0, 0, 0, 0, 0},
    '{RowPoint, 0, 0, 16'h7fff, 16'h8000, 1, 0, 0, 0},
    '{RowPoint, 0, 0, 16'h8000, 16'h7fff, 1, 0, 0, 0},
    '{RowPoint, 0, 0, 16'h0000, 16'h0000, 0, 1, 0, 0},
    '{RowCfg, RegSampleCount, 10'd4, 0, 0, 0, 0, 0, 0},
    '{RowCfg, RegStartIndex, 10'd2, 0, 0, 0, 0, 0, 0},
    '{RowCfg, RegDimsInUse, 10'd8, 0, 0, 0, 0, 0, 0},
    '{RowPoint, 0, 0, 16'h7fff, 16'h7fff, 1, 0, 0, 0},
    '{RowPoint, 0, 0, 16'h8000, 16'h8000, 1, 0, 0, 0},
    '{RowPoint, 0, 0, 16'h1234, 16'hfffb, 0, 0, 0, 0},
    '{RowPoint, 0, 0, 16'hffff, 16'h0001, 1, 1, 0, 0},
    '{RowCfg, RegDimsInUse, 10'd1, 0, 0, 0, 0, 0, 0},
    '{RowCfg, RegSampleCount, 10'd64, 0, 0, 0, 0, 0, 0},
    '{RowCfg, RegStartIndex, 10'd1023, 0, 0, 0, 0, 0, 0},
    '{RowPoint, 0, 0, 16'h0064, 16'hff9c, 1, 0, 0, 0},
    '{RowPoint, 0, 0, 16'hfff9, 16'h0003, 1, 0, 0, 0},
    '{RowPoint, 0, 0, 16'h8000, 16'h7fff, 1, 1, 0, 0}
  };

  initial begin
    fps_in_t p;
    int unsigned sent, cloud_len;
    bit all_masked;
    rst_n = 1'b0;
    start = 1'b0;
    point_word = '0;
    cfg_we = 1'b0;
    cfg_idx = RegSampleCount;
    cfg_data = '0;
    pts_loaded = 0;
    pts_valid = 0;
    num_samples = 0;
    first_centroid = 0;
    dim_count = 3;
    fail_count = 0;
    cycle_count = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == RowCfg) begin
        write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
      end else begin
        for (int d = 0; d < MaxDim; d++)
          p[2 + 16*d +: 16] = d[0] ? dir_rows[r].odd_c : dir_rows[r].even_c;
        p.point_valid = dir_rows[r].valid;
        p.last_point = dir_rows[r].last;
        send_point(p, 1'b1, dir_rows[r].typed, dir_rows[r].want_idx);
      end
    end

    sent = 0;
    while (sent < 97) begin
      case ($urandom_range(0, 5))
        0: write_reg(RegSampleCount, 10'($urandom_range(65, 127)));
        1: write_reg(RegSampleCount, 10'($urandom_range(0, 3)));
        default: write_reg(RegSampleCount, 10'($urandom_range(1, 16)));
      endcase
      cloud_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      write_reg(RegStartIndex, 10'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023)
                                                              : $urandom_range(0, cloud_len)));
      write_reg(RegDimsInUse, 10'($urandom_range(0, 15)));
      all_masked = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < cloud_len; i++) begin
        for (int d = 0; d < MaxDim; d++) p[2 + 16*d +: 16] = 16'($urandom());
        p.point_valid = !all_masked && ($urandom_range(0, 4) != 0);
        p.last_point = (i + 1 == cloud_len);
        send_point(p, sent < 80, 1'b0, 0);
        sent++;
      end
    end

    while (sample_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

[farthest_point_sampler.f]
design/fps_pkg.sv
design/farthest_point_sampler.sv
test/tb_top.sv
